[src/threshold_gated_pid_update_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the threshold gated PID update unit
// Immediate-implication and next-cycle-implication checks, reset aware.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_GATED_PID_UPDATE_UNIT_MACROS_SVH
`define THRESHOLD_GATED_PID_UPDATE_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TGPU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TGPU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tgpu_pkg.sv]
// ----------------------------------------------------------------------------
// tgpu_pkg
// Shared types and constants of the threshold gated PID update unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tgpu_pkg;

    // configuration register indexes
    localparam logic [3:0] CFG_PROP_GAIN    = 4'd0;
    localparam logic [3:0] CFG_INTEG_GAIN   = 4'd1;
    localparam logic [3:0] CFG_DERIV_GAIN   = 4'd2;
    localparam logic [3:0] CFG_INTEG_WEIGHT = 4'd3;
    localparam logic [3:0] CFG_STAT_WEIGHT  = 4'd4;
    localparam logic [3:0] CFG_HIGH_COEF    = 4'd5;
    localparam logic [3:0] CFG_LOW_COEF     = 4'd6;
    localparam logic [3:0] CFG_CTRL_LIMIT   = 4'd7;

    // width of one shared multiplier operand (signed)
    localparam int OPND_W = 33;

    // one issue to the multiply-accumulate unit
    typedef struct packed {
        logic valid;     // product enters the pipe
        logic clr;       // start a new sum with this product
        logic hi_shift;  // weight the product by 2^32
    } mac_op_t;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[src/threshold_gated_pid_update_unit.sv]
// ----------------------------------------------------------------------------
// threshold_gated_pid_update_unit
// Incremental PID update with EWMA integral, statistics gate and output divide.
// ----------------------------------------------------------------------------
// One item at a time. After an input transfer a 17-step sequencer drives every
// product through one shared 33x33 multiply-accumulate unit; at step 9 the
// serial divider starts and produces one quotient bit per cycle. The result is
// loaded into the output register once the divider is done and the output
// register is free; the next input is taken the cycle after that. Config
// writes must be issued only while the block is idle.
`default_nettype none

`include "threshold_gated_pid_update_unit_macros.svh"

module threshold_gated_pid_update_unit
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [3:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] error_sample,
    input  wire logic [31:0]        divisor,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [31:0]             drive_out,
    output logic                    gate_open,
    output logic signed [31:0]      integ_out,
    output logic signed [31:0]      corr_out
);

    localparam int DVD_W = 33 + FRAC_BITS;
    localparam int WGT_W = (FRAC_BITS + 1 > 17) ? FRAC_BITS + 1 : 17;
    localparam int CF_W  = (FRAC_BITS + 1 > 24) ? FRAC_BITS + 1 : 24;
    localparam logic [32:0]       ONE_Q      = 33'd1 << FRAC_BITS;
    localparam logic [WGT_W-1:0]  STAT_W_RST = WGT_W'(((64'd1 << FRAC_BITS) * 5 + 50) / 100);
    localparam logic [CF_W-1:0]   COEF_RST   = CF_W'(64'd1 << FRAC_BITS);
    localparam logic signed [63:0] S32_MAX   = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN   = -64'sd2147483648;

    // sequencer steps
    localparam logic [4:0] STEP_INTEG_OLD  = 5'd0;
    localparam logic [4:0] STEP_INTEG_NEW  = 5'd1;
    localparam logic [4:0] STEP_HIGH_BAND  = 5'd2;
    localparam logic [4:0] STEP_KI         = 5'd3;
    localparam logic [4:0] STEP_KP         = 5'd4;
    localparam logic [4:0] STEP_KD         = 5'd5;
    localparam logic [4:0] STEP_LOW_BAND   = 5'd6;
    localparam logic [4:0] STEP_MEAN_OLD   = 5'd7;
    localparam logic [4:0] STEP_MEAN_NEW   = 5'd8;
    localparam logic [4:0] STEP_LAG_PROD   = 5'd9;
    localparam logic [4:0] STEP_DEV_OLD    = 5'd10;
    localparam logic [4:0] STEP_DEV_NEW    = 5'd11;
    localparam logic [4:0] STEP_CORR_LO    = 5'd12;
    localparam logic [4:0] STEP_CORR_HI    = 5'd13;
    localparam logic [4:0] STEP_CORR_OLD   = 5'd14;
    localparam logic [4:0] STEP_DRAIN      = 5'd15;
    localparam logic [4:0] STEP_LAST       = 5'd16;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FINISH} state_t;

    // configuration
    logic [23:0]       prop_gain_reg;
    logic [23:0]       integ_gain_reg;
    logic [23:0]       deriv_gain_reg;
    logic [WGT_W-1:0]  integ_weight_reg;
    logic [WGT_W-1:0]  stat_weight_reg;
    logic [CF_W-1:0]   high_coef_reg;
    logic [CF_W-1:0]   low_coef_reg;
    logic [30:0]       ctrl_limit_reg;

    // controller state
    logic signed [31:0] last_error_reg;
    logic signed [31:0] integ_acc_reg;
    logic signed [31:0] err_mean_reg;
    logic [31:0]        err_dev_reg;
    logic signed [31:0] err_corr_reg;
    logic [31:0]        last_drive_reg;

    // working registers
    state_t             state_reg;
    logic [4:0]         step_reg;
    logic signed [31:0] e_reg;
    logic [31:0]        div_reg;
    logic               hi_neg_reg;
    logic signed [31:0] ctrl_reg;
    logic               gate_reg;
    logic signed [63:0] t_reg;

    // output register
    logic               out_valid_reg;
    logic [31:0]        drive_out_reg;
    logic               gate_open_reg;
    logic signed [31:0] integ_out_reg;
    logic signed [31:0] corr_out_reg;

    tgpu_pkg::mac_op_t                     op;
    logic signed [tgpu_pkg::OPND_W-1:0]    opnd_a;
    logic signed [tgpu_pkg::OPND_W-1:0]    opnd_b;
    logic signed [63:0]                    acc;
    logic signed [63:0]                    acc_shr;

    logic [32:0]        wi_ext;
    logic [32:0]        ws_ext;
    logic [32:0]        wi;
    logic [32:0]        ws;
    logic [32:0]        omwi;
    logic [32:0]        omws;
    logic [32:0]        e_minus_prev;
    logic [32:0]        mean_diff;
    logic [32:0]        adev;
    logic signed [63:0] mean_64;
    logic signed [63:0] hi_64;
    logic signed [63:0] lo_64;
    logic signed [63:0] lim_64;
    logic signed [63:0] neg_lim_64;
    logic signed [31:0] ctrl_clamped;
    logic signed [31:0] ctrl_gated;
    logic signed [33:0] sum_34;
    logic [32:0]        dvd_sum;
    logic [32:0]        drive_ext;
    logic [DVD_W-1:0]   div_dividend;
    logic               div_start;
    tgpu_pkg::div_stat_t div_stat;
    logic [31:0]        div_quot;
    logic               in_xfer;
    logic               out_load;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;

    // weights above one act as one
    assign wi_ext = 33'(integ_weight_reg);
    assign ws_ext = 33'(stat_weight_reg);
    assign wi     = (wi_ext > ONE_Q) ? ONE_Q : wi_ext;
    assign ws     = (ws_ext > ONE_Q) ? ONE_Q : ws_ext;
    assign omwi   = ONE_Q - wi;
    assign omws   = ONE_Q - ws;

    assign e_minus_prev = {e_reg[31], e_reg} - {last_error_reg[31], last_error_reg};
    assign mean_diff    = {e_reg[31], e_reg} - {err_mean_reg[31], err_mean_reg};
    assign adev         = mean_diff[32] ? (33'd0 - mean_diff) : mean_diff;

    assign acc_shr = acc >>> FRAC_BITS;

    assign mean_64    = {{32{err_mean_reg[31]}}, err_mean_reg};
    assign hi_64      = mean_64 + acc_shr;
    assign lo_64      = mean_64 - acc_shr;
    assign lim_64     = $signed({33'b0, ctrl_limit_reg});
    assign neg_lim_64 = -lim_64;

    always_comb
    begin
        if (acc_shr > lim_64)
            ctrl_clamped = lim_64[31:0];
        else if (acc_shr < neg_lim_64)
            ctrl_clamped = neg_lim_64[31:0];
        else
            ctrl_clamped = acc_shr[31:0];
    end

    // closed gate drops the increment
    assign ctrl_gated   = gate_reg ? ctrl_reg : 32'sd0;
    assign sum_34       = $signed({2'b0, last_drive_reg})
                        + $signed({{2{ctrl_gated[31]}}, ctrl_gated});
    assign dvd_sum      = sum_34[33] ? 33'd0 : sum_34[32:0];
    assign drive_ext    = {1'b0, last_drive_reg};
    assign div_dividend = {dvd_sum, {FRAC_BITS{1'b0}}};
    assign div_start    = (state_reg == ST_RUN) && (step_reg == STEP_LAG_PROD);

    // operand selection for the shared multiplier
    always_comb
    begin
        op     = '0;
        opnd_a = '0;
        opnd_b = '0;
        if (state_reg == ST_RUN)
        begin
            unique case (step_reg)
                STEP_INTEG_OLD:
                begin
                    op     = '{valid: 1'b1, clr: 1'b1, hi_shift: 1'b0};
                    opnd_a = $signed({integ_acc_reg[31], integ_acc_reg});
                    opnd_b = $signed(omwi);
                end
                STEP_INTEG_NEW:
                begin
                    op     = '{valid: 1'b1, clr: 1'b0, hi_shift: 1'b0};
                    opnd_a = $signed({e_reg[31], e_reg});
                    opnd_b = $signed(wi);
                end
                STEP_HIGH_BAND:
                begin
                    op     = '{valid: 1'b1, clr: 1'b1, hi_shift: 1'b0};
                    opnd_a = $signed({1'b0, err_dev_reg});
                    opnd_b = $signed(33'(high_coef_reg));
                end
                STEP_KI:
                begin
                    // new integral straight from the accumulator
                    op     = '{valid: 1'b1, clr: 1'b1, hi_shift: 1'b0};
                    opnd_a = $signed({acc_shr[31], acc_shr[31:0]});
                    opnd_b = $signed(33'(integ_gain_reg));
                end
                STEP_KP:
                begin
                    op     = '{valid: 1'b1, clr: 1'b0, hi_shift: 1'b0};
                    opnd_a = $signed({e_reg[31], e_reg});
                    opnd_b = $signed(33'(prop_gain_reg));
                end
                STEP_KD:
                begin
                    op     = '{valid: 1'b1, clr: 1'b0, hi_shift: 1'b0};
                    opnd_a = $signed(e_minus_prev);
                    opnd_b = $signed(33'(deriv_gain_reg));
                end
                STEP_LOW_BAND:
                begin
                    op     = '{valid: 1'b1, clr: 1'b1, hi_shift: 1'b0};
                    opnd_a = $signed({1'b0, err_dev_reg});
                    opnd_b = $signed(33'(low_coef_reg));
                end
                STEP_MEAN_OLD:
                begin
                    op     = '{valid: 1'b1, clr: 1'b1, hi_shift: 1'b0};
                    opnd_a = $signed({err_mean_reg[31], err_mean_reg});
                    opnd_b = $signed(omws);
                end
                STEP_MEAN_NEW:
                begin
                    op     = '{valid: 1'b1, clr: 1'b0, hi_shift: 1'b0};
                    opnd_a = $signed({e_reg[31], e_reg});
                    opnd_b = $signed(ws);
                end
                STEP_LAG_PROD:
                begin
                    op     = '{valid: 1'b1, clr: 1'b1, hi_shift: 1'b0};
                    opnd_a = $signed({last_error_reg[31], last_error_reg});
                    opnd_b = $signed({e_reg[31], e_reg});
                end
                STEP_DEV_OLD:
                begin
                    op     = '{valid: 1'b1, clr: 1'b1, hi_shift: 1'b0};
                    opnd_a = $signed({1'b0, err_dev_reg});
                    opnd_b = $signed(omws);
                end
                STEP_DEV_NEW:
                begin
                    op     = '{valid: 1'b1, clr: 1'b0, hi_shift: 1'b0};
                    opnd_a = $signed(adev);
                    opnd_b = $signed(ws);
                end
                STEP_CORR_LO:
                begin
                    op     = '{valid: 1'b1, clr: 1'b1, hi_shift: 1'b0};
                    opnd_a = $signed({1'b0, t_reg[31:0]});
                    opnd_b = $signed(ws);
                end
                STEP_CORR_HI:
                begin
                    op     = '{valid: 1'b1, clr: 1'b0, hi_shift: 1'b1};
                    opnd_a = $signed({t_reg[63], t_reg[63:32]});
                    opnd_b = $signed(ws);
                end
                STEP_CORR_OLD:
                begin
                    op     = '{valid: 1'b1, clr: 1'b0, hi_shift: 1'b0};
                    opnd_a = $signed({err_corr_reg[31], err_corr_reg});
                    opnd_b = $signed(omws);
                end
                default:
                begin
                    op = '0;
                end
            endcase
        end
    end

    tgpu_mac u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .opnd_a (opnd_a),
        .opnd_b (opnd_b),
        .acc    (acc)
    );

    tgpu_div
    #(
        .DVD_W (DVD_W)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    assign out_load = (state_reg == ST_FINISH) && div_stat.done
                   && (!out_valid_reg || out_ready);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg    <= '0;
            integ_gain_reg   <= '0;
            deriv_gain_reg   <= '0;
            integ_weight_reg <= '0;
            stat_weight_reg  <= STAT_W_RST;
            high_coef_reg    <= COEF_RST;
            low_coef_reg     <= COEF_RST;
            ctrl_limit_reg   <= 31'h7FFF_FFFF;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tgpu_pkg::CFG_PROP_GAIN:    prop_gain_reg    <= cfg_data[23:0];
                tgpu_pkg::CFG_INTEG_GAIN:   integ_gain_reg   <= cfg_data[23:0];
                tgpu_pkg::CFG_DERIV_GAIN:   deriv_gain_reg   <= cfg_data[23:0];
                tgpu_pkg::CFG_INTEG_WEIGHT: integ_weight_reg <= WGT_W'(cfg_data[16:0]);
                tgpu_pkg::CFG_STAT_WEIGHT:  stat_weight_reg  <= WGT_W'(cfg_data[16:0]);
                tgpu_pkg::CFG_HIGH_COEF:    high_coef_reg    <= CF_W'(cfg_data[23:0]);
                tgpu_pkg::CFG_LOW_COEF:     low_coef_reg     <= CF_W'(cfg_data[23:0]);
                tgpu_pkg::CFG_CTRL_LIMIT:   ctrl_limit_reg   <= cfg_data[30:0];
                default:                    ctrl_limit_reg   <= ctrl_limit_reg;
            endcase
        end
    end

    // sequencer, controller state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            last_error_reg <= '0;
            integ_acc_reg  <= '0;
            err_mean_reg   <= '0;
            err_dev_reg    <= '0;
            err_corr_reg   <= '0;
            last_drive_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !out_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= ST_RUN;
                        step_reg  <= STEP_INTEG_OLD;
                    end
                end
                ST_RUN:
                begin
                    step_reg <= step_reg + 5'd1;
                    case (step_reg)
                        STEP_KI:
                            integ_acc_reg <= acc_shr[31:0];
                        STEP_MEAN_NEW:
                            err_mean_reg <= err_mean_reg;
                        STEP_DEV_OLD:
                            err_mean_reg <= acc_shr[31:0];
                        STEP_CORR_HI:
                            err_dev_reg <= (acc_shr[63:32] != 32'd0)
                                           ? 32'hFFFF_FFFF : acc_shr[31:0];
                        STEP_LAST:
                        begin
                            if (acc_shr > S32_MAX)
                                err_corr_reg <= S32_MAX[31:0];
                            else if (acc_shr < S32_MIN)
                                err_corr_reg <= S32_MIN[31:0];
                            else
                                err_corr_reg <= acc_shr[31:0];
                            last_error_reg <= e_reg;
                            state_reg      <= ST_FINISH;
                        end
                        default:
                        begin
                            state_reg <= ST_RUN;
                        end
                    endcase
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        last_drive_reg <= div_quot;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload captures
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            e_reg   <= error_sample;
            div_reg <= divisor;
        end
        if (state_reg == ST_RUN)
        begin
            case (step_reg)
                STEP_KP:       hi_neg_reg <= hi_64[63];
                STEP_LOW_BAND: ctrl_reg   <= ctrl_reg;
                STEP_MEAN_OLD: ctrl_reg   <= ctrl_clamped;
                STEP_MEAN_NEW: gate_reg   <= hi_neg_reg || (!lo_64[63] && (lo_64 != 64'sd0));
                STEP_DEV_NEW:  t_reg      <= acc_shr;
                default:       t_reg      <= t_reg;
            endcase
        end
        if (out_load)
        begin
            drive_out_reg <= div_quot;
            gate_open_reg <= gate_reg;
            integ_out_reg <= integ_acc_reg;
            corr_out_reg  <= err_corr_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive_out = drive_out_reg;
    assign gate_open = gate_open_reg;
    assign integ_out = integ_out_reg;
    assign corr_out  = corr_out_reg;

    `TGPU_ASSERT_NOW(a_div_start_idle, clk, rst_n, div_start, !div_stat.busy, "divider restarted while busy")
    `TGPU_ASSERT_NEXT(a_xfer_starts_run, clk, rst_n, in_xfer, (state_reg == ST_RUN) && (step_reg == STEP_INTEG_OLD), "input transfer did not start the sequencer")
    `TGPU_ASSERT_NOW(a_gate_closed_hold, clk, rst_n, div_start && !gate_reg, dvd_sum == drive_ext, "closed gate changed the drive")
    `TGPU_ASSERT_NOW(a_load_after_run, clk, rst_n, out_load, !div_stat.busy && !in_ready, "result loaded while divider busy")

endmodule

`default_nettype wire

[src/tgpu_mac.sv]
// ----------------------------------------------------------------------------
// tgpu_mac
// Shared signed multiply-accumulate unit: registered product, then 64-bit sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tgpu_mac
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire tgpu_pkg::mac_op_t                      op,
    input  wire logic signed [tgpu_pkg::OPND_W-1:0]     opnd_a,
    input  wire logic signed [tgpu_pkg::OPND_W-1:0]     opnd_b,
    output logic signed [63:0]                          acc
);

    logic signed [2*tgpu_pkg::OPND_W-1:0] prod;
    logic signed [63:0]                   prod_reg;
    logic                                 pv_reg;
    logic                                 pclr_reg;
    logic signed [63:0]                   acc_reg;

    assign prod = opnd_a * opnd_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg   <= 1'b0;
            pclr_reg <= 1'b0;
        end
        else
        begin
            pv_reg   <= op.valid;
            pclr_reg <= op.clr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.valid)
        begin
            if (op.hi_shift)
                prod_reg <= $signed({prod[31:0], 32'b0});
            else
                prod_reg <= prod[63:0];
        end
        if (pv_reg)
        begin
            // sums wrap modulo 2^64; every final value fits
            if (pclr_reg)
                acc_reg <= prod_reg;
            else
                acc_reg <= acc_reg + prod_reg;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

[src/tgpu_div.sv]
// ----------------------------------------------------------------------------
// tgpu_div
// Restoring serial divider, one quotient bit per cycle, saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tgpu_div
#(
    parameter int DVD_W = 49
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DVD_W-1:0]     dividend,
    input  wire logic [31:0]          divisor,
    output tgpu_pkg::div_stat_t       stat,
    output logic [31:0]               quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      rem_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [31:0]      dsr_reg;
    logic [32:0]      rem_sh;
    logic [33:0]      diff;
    logic             ge;

    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b0, dsr_reg};
    assign ge     = !diff[33];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // shift dividend out the top, quotient bits in at the bottom
            rem_reg <= ge ? diff[31:0] : rem_sh[31:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    // zero divisor and oversize quotient both saturate
    assign quotient  = ((dvd_reg[DVD_W-1:32] != '0) || (dsr_reg == 32'd0))
                       ? 32'hFFFF_FFFF : dvd_reg[31:0];

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the threshold gated PID update unit: a directed
// table, then random items over several gain and weight settings, all
// compared field by field against a local fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam int FB = 16;
    localparam longint ONE = 64'sd1 << FB;
    localparam longint M32 = 64'hFFFF_FFFF;

    typedef struct {
        logic [31:0] drive;
        logic        gate;
        logic [31:0] integ;
        logic [31:0] corr;
    } pid_result_t;

    typedef struct {
        logic [31:0] err;
        logic [31:0] div;
        logic        has_gold;
        pid_result_t gold;
    } stim_row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0, in_valid = 0, out_ready = 0;
    logic [3:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic signed [31:0] error_sample = '0;
    logic [31:0] divisor = 32'd1;
    logic cfg_ready, in_ready, out_valid, gate_open;
    logic [31:0] drive_out;
    logic signed [31:0] integ_out, corr_out;

    threshold_gated_pid_update_unit dut (.*);

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    // predictor copy of registers and state
    longint kp, ki, kd, wint, wstat, hcoef, lcoef, climit;
    longint prev_err, integ_acc, mean_acc, corr_acc;
    longint unsigned dev_acc, drive_acc;

    pid_result_t pending_results[$];
    stim_row_t   dir_rows[$];
    int          fail_count = 0;
    int          sent_count = 0;
    int          got_count = 0;
    int          gate_count = 0;
    int          hold_off = 0;

    function automatic longint floor_shift(longint x);
        return x >>> FB;
    endfunction

    task automatic reset_model();
        kp = 0; ki = 0; kd = 0; wint = 0; wstat = 3277;
        hcoef = ONE; lcoef = ONE; climit = 64'h7FFF_FFFF;
        prev_err = 0; integ_acc = 0; mean_acc = 0; corr_acc = 0;
        dev_acc = 0; drive_acc = 0;
    endtask

    task automatic write_model(logic [3:0] idx, logic [31:0] val);
        case (idx)
            tgpu_pkg::CFG_PROP_GAIN:    kp = val[23:0];
            tgpu_pkg::CFG_INTEG_GAIN:   ki = val[23:0];
            tgpu_pkg::CFG_DERIV_GAIN:   kd = val[23:0];
            tgpu_pkg::CFG_INTEG_WEIGHT: wint = val[16:0];
            tgpu_pkg::CFG_STAT_WEIGHT:  wstat = val[16:0];
            tgpu_pkg::CFG_HIGH_COEF:    hcoef = val[23:0];
            tgpu_pkg::CFG_LOW_COEF:     lcoef = val[23:0];
            tgpu_pkg::CFG_CTRL_LIMIT:   climit = val[30:0];
            default: ;
        endcase
    endtask

    function automatic pid_result_t step_pid(logic [31:0] err_bits, logic [31:0] div_bits);
        pid_result_t r;
        longint e, prev, wi, ws, ctrl, hi, lo, sum, mnew, corr;
        longint unsigned q, adev, dnew, ddiv;
        e = longint'(signed'(err_bits));
        ddiv = div_bits;
        prev = prev_err;
        wi = (wint > ONE) ? ONE : wint;
        ws = (wstat > ONE) ? ONE : wstat;
        integ_acc = floor_shift(integ_acc * (ONE - wi) + e * wi);
        ctrl = floor_shift(kp * e + ki * integ_acc + kd * (e - prev));
        if (ctrl > climit) ctrl = climit;
        if (ctrl < -climit) ctrl = -climit;
        hi = mean_acc + longint'((dev_acc * longint'(hcoef)) >> FB);
        lo = mean_acc - longint'((dev_acc * longint'(lcoef)) >> FB);
        r.gate = (hi < 0) || (lo > 0);
        if (!r.gate) ctrl = 0;
        sum = longint'(drive_acc) + ctrl;
        if (sum < 0) sum = 0;
        if (ddiv == 0) q = M32;
        else
        begin
            q = (longint'(sum) << FB) / ddiv;
            if (q > M32) q = M32;
        end
        drive_acc = q;
        mnew = floor_shift(mean_acc * (ONE - ws) + e * ws);
        mean_acc = mnew;
        adev = (e >= mnew) ? (e - mnew) : (mnew - e);
        dnew = (dev_acc * longint'(ONE - ws) + adev * longint'(ws)) >> FB;
        if (dnew > M32) dnew = M32;
        dev_acc = dnew;
        corr = floor_shift(prev * e) * ws + corr_acc * (ONE - ws);
        corr = floor_shift(corr);
        if (corr > 64'sh7FFF_FFFF) corr = 64'sh7FFF_FFFF;
        if (corr < -64'sh8000_0000) corr = -64'sh8000_0000;
        corr_acc = corr;
        prev_err = e;
        r.drive = q[31:0];
        r.integ = integ_acc[31:0];
        r.corr = corr_acc[31:0];
        return r;
    endfunction

    task automatic wait_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        write_model(idx, val);
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending_results.size() != 0) @(posedge clk);
        wait_cycles(80);
    endtask

    // send one item; the predictor runs at the transfer
    task automatic send_item(logic [31:0] err, logic [31:0] div, bit use_gold,
                             pid_result_t gold, int gap);
        pid_result_t r;
        if (gap > 0)
        begin
            in_valid <= 0;
            wait_cycles(gap);
        end
        in_valid <= 1;
        error_sample <= err;
        divisor <= div;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        r = step_pid(err, div);
        if (use_gold && ((r.drive !== gold.drive) || (r.gate !== gold.gate)
                         || (r.integ !== gold.integ) || (r.corr !== gold.corr)))
        begin
            $error("table row %0d disagrees with predictor", sent_count);
            fail_count++;
        end
        pending_results.push_back(use_gold ? gold : r);
        sent_count++;
    endtask

    function automatic logic [31:0] rand_err();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h40000)
                                           : -$urandom_range(0, 32'h40000);
            default: return $urandom_range(0, 1) ? 32'h10000 + $urandom_range(0, 32'h8000)
                                                 : -(32'h10000 + $urandom_range(0, 32'h8000));
        endcase
    endfunction

    function automatic logic [31:0] rand_div();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(1, 16);
            2: return $urandom_range(0, 20) == 0 ? 32'hFFFF_FFFF : 32'h1;
            default: return 32'h10000 + $urandom_range(0, 32'h2000) - 32'h1000;
        endcase
    endfunction

    // receiver: random stalls, plus one long hold-off
    initial
    begin : result_sink
        pid_result_t exp_r;
        int stall;
        wait (rst_n);
        forever
        begin
            if (hold_off > 0)
            begin
                out_ready <= 0;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                out_ready <= 0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected");
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                got_count++;
                if (gate_open) gate_count++;
                if (drive_out !== exp_r.drive)
                begin
                    $error("drive_out exp %h got %h", exp_r.drive, drive_out);
                    fail_count++;
                end
                if (gate_open !== exp_r.gate)
                begin
                    $error("gate_open exp %b got %b", exp_r.gate, gate_open);
                    fail_count++;
                end
                if (integ_out !== exp_r.integ)
                begin
                    $error("integ_out exp %h got %h", exp_r.integ, integ_out);
                    fail_count++;
                end
                if (corr_out !== exp_r.corr)
                begin
                    $error("corr_out exp %h got %h", exp_r.corr, corr_out);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : run_limit
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : main_seq
        pid_result_t none;
        int phase;
        none = '{default: '0};
        reset_model();
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed table; only rows readable at a glance carry a typed result
        dir_rows = '{
            '{32'h0000_0000, 32'h0001_0000, 1, '{32'h0, 1'b0, 32'h0, 32'h0}},
            '{32'h7FFF_FFFF, 32'h0000_0000, 1, '{32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0}},
            '{32'h8000_0000, 32'hFFFF_FFFF, 0, none},
            '{32'h0001_0000, 32'h0000_0001, 0, none},
            '{32'hFFFF_0000, 32'h0001_0000, 0, none}
        };
        foreach (dir_rows[i])
            send_item(dir_rows[i].err, dir_rows[i].div, dir_rows[i].has_gold,
                      dir_rows[i].gold, 0);
        drain();

        // open gains and weights, gate with zero coefficients
        write_reg(tgpu_pkg::CFG_PROP_GAIN, 32'h01_0000);
        write_reg(tgpu_pkg::CFG_INTEG_GAIN, 32'h00_8000);
        write_reg(tgpu_pkg::CFG_DERIV_GAIN, 32'h00_4000);
        write_reg(tgpu_pkg::CFG_INTEG_WEIGHT, 32'h1_0000);
        write_reg(tgpu_pkg::CFG_STAT_WEIGHT, 32'h1_FFFF);
        write_reg(tgpu_pkg::CFG_HIGH_COEF, 32'h0);
        write_reg(tgpu_pkg::CFG_LOW_COEF, 32'h0);
        write_reg(tgpu_pkg::CFG_CTRL_LIMIT, 32'h0);
        write_reg(4'd12, 32'hDEAD_BEEF);
        foreach (dir_rows[i])
            send_item(dir_rows[i].err, dir_rows[i].div, 0, none, 0);
        send_item(32'h0002_0000, 32'h0001_0000, 0, none, 0);
        send_item(32'hFFFE_0000, 32'h0000_8000, 0, none, 0);
        drain();
        write_reg(tgpu_pkg::CFG_CTRL_LIMIT, 32'h7FFF_FFFF);
        write_reg(tgpu_pkg::CFG_PROP_GAIN, 32'hFF_FFFF);
        write_reg(tgpu_pkg::CFG_DERIV_GAIN, 32'hFF_FFFF);
        write_reg(tgpu_pkg::CFG_INTEG_GAIN, 32'hFF_FFFF);
        foreach (dir_rows[i])
            send_item(dir_rows[i].err, dir_rows[i].div, 0, none, 0);
        send_item(32'h8000_0000, 32'h0000_0001, 0, none, 0);
        send_item(32'h7FFF_FFFF, 32'h0000_0001, 0, none, 0);
        drain();

        // random phases with fresh settings
        for (phase = 0; phase < 6; phase++)
        begin
            write_reg(tgpu_pkg::CFG_PROP_GAIN,
                      phase == 5 ? 32'hFF_FFFF : $urandom_range(0, 32'h3_0000));
            write_reg(tgpu_pkg::CFG_INTEG_GAIN, $urandom_range(0, 32'h2_0000));
            write_reg(tgpu_pkg::CFG_DERIV_GAIN,
                      phase == 5 ? 32'hFF_FFFF : $urandom_range(0, 32'h1_0000));
            write_reg(tgpu_pkg::CFG_INTEG_WEIGHT, $urandom_range(0, 32'h1_FFFF));
            write_reg(tgpu_pkg::CFG_STAT_WEIGHT,
                      phase == 0 ? 32'h0 : $urandom_range(0, 32'h1_2000));
            write_reg(tgpu_pkg::CFG_HIGH_COEF, $urandom_range(0, 3) == 0 ? 32'hFF_FFFF
                                               : $urandom_range(0, 32'h2_0000));
            write_reg(tgpu_pkg::CFG_LOW_COEF, $urandom_range(0, 32'h2_0000));
            write_reg(tgpu_pkg::CFG_CTRL_LIMIT, $urandom_range(0, 1) ? $urandom()
                                                : $urandom_range(0, 32'h4_0000));
            if (phase == 2) hold_off = 400;
            repeat (105)
                send_item(rand_err(), rand_div(), 0, none,
                          ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19));
            drain();
        end

        $display("Ran %0d items under nine register settings, one long output stall included.",
                 sent_count);
        $display("Checked %0d results; the gate was open on %0d of them.",
                 got_count, gate_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
